>>> hdl/rsht_pkg.sv
package rsht_pkg;

  // Field widths
  localparam int unsigned CountW  = 32;
  localparam int unsigned VelW    = 18;
  localparam int unsigned PosW    = 16;
  localparam int unsigned OffW    = PosW + 1;
  localparam int unsigned SpeedW  = 18;
  localparam int unsigned DivW    = 16;
  localparam int unsigned ThrW    = 17;
  localparam int unsigned CfgW    = 17;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned EventW  = 2;

  // Internal datapath widths
  localparam int unsigned ProdW = VelW + OffW;   // one signed product
  localparam int unsigned SqW   = 34;            // sum of three squares
  localparam int unsigned DotW  = 36;            // signed dot product
  localparam int unsigned NumW  = 35;            // dividend / radicand shifter
  localparam int unsigned RootW = 17;            // square root result
  localparam int unsigned RemW  = 20;            // partial remainder
  localparam int unsigned CntW  = 6;

  // Register indexes
  localparam logic [CfgIdxW-1:0] REG_CLOCK_DIVISOR   = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_START_THRESHOLD = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_STOP_THRESHOLD  = 2'd2;

  // Register reset values
  localparam logic [DivW-1:0] DIVISOR_RESET   = 16'd1;
  localparam logic [ThrW-1:0] START_THR_RESET = 17'd1000;
  localparam logic [ThrW-1:0] STOP_THR_RESET  = 17'd110;

  // Event codes
  localparam logic [EventW-1:0] EV_NONE    = 2'd0;
  localparam logic [EventW-1:0] EV_RESTART = 2'd1;
  localparam logic [EventW-1:0] EV_STOP    = 2'd2;

  // Speed limits
  localparam logic [SpeedW-1:0] SPEED_MAX = 18'h1FFFF;
  localparam logic [SpeedW-1:0] SPEED_MIN = 18'h20000;

  // Iteration counts of each phase (last count value)
  localparam logic [CntW-1:0] MOD_LAST  = 6'd31;
  localparam logic [CntW-1:0] MUL_LAST  = 6'd6;
  localparam logic [CntW-1:0] SQRT_LAST = 6'd16;
  localparam logic [CntW-1:0] DIV_LAST  = 6'd34;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_MOD  = 6'b000010,
    ST_MUL  = 6'b000100,
    ST_SQRT = 6'b001000,
    ST_DIV  = 6'b010000,
    ST_DONE = 6'b100000
  } state_e;

endpackage

>>> hdl/radial_speed_hysteresis_trigger.sv
// Radial speed hysteresis trigger.
// Input channel (in_valid_i / in_ready_o) carries one tick: clock count, velocity,
// point position and anchor position. Output channel (out_valid_o / out_ready_i)
// returns one result per tick: sampled flag, event code, playing flag, radial speed.
// Configuration is a plain write port (cfg_we_i, cfg_idx_i, cfg_data_i): index 0 clock
// divisor, 1 start threshold, 2 stop threshold; other indexes are ignored.
// One tick at a time is processed by a sequencer around a single compare-subtract
// unit and a single 18x17 multiplier:
//   divisor test (one remainder bit a cycle),
//   three squares and three products (multiplier plus accumulator),
//   square root (one root bit a cycle), divide (one quotient
//   bit a cycle), then the output register is loaded once it is free.
// A tick that fails the divisor test skips straight to the result and a
// zero-distance tick skips the divide; the next tick is accepted in the cycle
// after the result is loaded.
// While the receiver stalls, the result is held in the output register; a following
// tick may still be accepted and processed, and it waits for the output register.
// Reset clears the playing flag, empties the output register and restores the
// register defaults (divisor 1, start 1000, stop 110).
module radial_speed_hysteresis_trigger (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration
  input  logic                              cfg_we_i,
  input  logic [rsht_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [rsht_pkg::CfgW-1:0]         cfg_data_i,
  // input transaction
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [rsht_pkg::CountW-1:0]       clock_count_i,
  input  logic signed [rsht_pkg::VelW-1:0]  vel_x_i,
  input  logic signed [rsht_pkg::VelW-1:0]  vel_y_i,
  input  logic signed [rsht_pkg::VelW-1:0]  vel_z_i,
  input  logic signed [rsht_pkg::PosW-1:0]  pos_x_i,
  input  logic signed [rsht_pkg::PosW-1:0]  pos_y_i,
  input  logic signed [rsht_pkg::PosW-1:0]  pos_z_i,
  input  logic signed [rsht_pkg::PosW-1:0]  anchor_x_i,
  input  logic signed [rsht_pkg::PosW-1:0]  anchor_y_i,
  input  logic signed [rsht_pkg::PosW-1:0]  anchor_z_i,
  // output transaction
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              sampled_o,
  output logic [rsht_pkg::EventW-1:0]       event_res_o,
  output logic                              playing_now_o,
  output logic signed [rsht_pkg::SpeedW-1:0] radial_speed_o
);
  import rsht_pkg::*;

  // Configuration registers
  logic [DivW-1:0] divisor_q;
  logic [ThrW-1:0] start_thr_q;
  logic [ThrW-1:0] stop_thr_q;

  // Sequencer
  state_e          state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  // Tick operands
  logic signed [VelW-1:0] vx_q, vy_q, vz_q;
  logic signed [OffW-1:0] dx_q, dy_q, dz_q;

  // Arithmetic state
  logic signed [ProdW-1:0] prod_q, prod_d;
  logic [SqW-1:0]          sq_q, sq_d;
  logic signed [DotW-1:0]  dot_q, dot_d;
  logic [NumW-1:0]         num_q, num_d;
  logic [RemW-1:0]         rem_q, rem_d;
  logic [RootW-1:0]        root_q, root_d;
  logic                    neg_q, neg_d;
  logic                    smp_q, smp_d;
  logic                    zd_q, zd_d;

  // Kept flag and output register
  logic                    playing_q, playing_d;
  logic                    out_valid_q, out_valid_d;
  logic                    out_smp_q, out_smp_d;
  logic [EventW-1:0]       out_ev_q, out_ev_d;
  logic                    out_play_q, out_play_d;
  logic [SpeedW-1:0]       out_speed_q, out_speed_d;

  logic                    in_fire;
  logic                    out_free;

  // Shared compare-subtract unit
  logic [RemW-1:0]         cs_t, cs_op;
  logic [RemW:0]           cs_diff;
  logic                    cs_ge;

  // Shared multiplier operands
  logic signed [VelW-1:0]  mul_a;
  logic signed [OffW-1:0]  mul_b;
  logic signed [DotW-1:0]  acc_in, acc_sum;

  // Result evaluation
  logic [DivW-1:0]         div_eff;
  logic [SpeedW-1:0]       speed_res;
  logic                    start_hit, stop_hit, rem_nz;
  logic [DotW-1:0]         dot_mag;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign div_eff    = (divisor_q == '0) ? DivW'(1) : divisor_q;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      divisor_q   <= DIVISOR_RESET;
      start_thr_q <= START_THR_RESET;
      stop_thr_q  <= STOP_THR_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_CLOCK_DIVISOR:   divisor_q   <= cfg_data_i[DivW-1:0];
        REG_START_THRESHOLD: start_thr_q <= cfg_data_i[ThrW-1:0];
        REG_STOP_THRESHOLD:  stop_thr_q  <= cfg_data_i[ThrW-1:0];
        default: ;
      endcase
    end
  end

  // Select compare-subtract operands by phase
  always_comb begin
    unique case (state_q)
      ST_SQRT: begin
        cs_t  = {rem_q[RemW-3:0], num_q[NumW-1 -: 2]};
        cs_op = {1'b0, root_q, 2'b01};
      end
      ST_DIV: begin
        cs_t  = {rem_q[RemW-2:0], num_q[NumW-1]};
        cs_op = RemW'(root_q);
      end
      ST_MOD: begin
        cs_t  = {rem_q[RemW-2:0], num_q[NumW-1]};
        cs_op = RemW'(div_eff);
      end
      default: begin
        cs_t  = '0;
        cs_op = '0;
      end
    endcase
    cs_diff = {1'b0, cs_t} - {1'b0, cs_op};
    cs_ge   = !cs_diff[RemW];
  end

  // Select multiplier operands: three squares, then three velocity products
  always_comb begin
    unique case (cnt_q[2:0])
      3'd0:    begin mul_a = VelW'(dx_q); mul_b = dx_q; end
      3'd1:    begin mul_a = VelW'(dy_q); mul_b = dy_q; end
      3'd2:    begin mul_a = VelW'(dz_q); mul_b = dz_q; end
      3'd3:    begin mul_a = vx_q;        mul_b = dx_q; end
      3'd4:    begin mul_a = vy_q;        mul_b = dy_q; end
      3'd5:    begin mul_a = vz_q;        mul_b = dz_q; end
      default: begin mul_a = '0;          mul_b = '0;   end
    endcase
    acc_in  = (cnt_q <= CntW'(3)) ? $signed({{(DotW-SqW){1'b0}}, sq_q}) : dot_q;
    acc_sum = acc_in + DotW'(prod_q);
  end

  // Evaluate speed and trigger from quotient, remainder and sign
  always_comb begin
    rem_nz  = (rem_q != '0);
    dot_mag = dot_q[DotW-1] ? DotW'(-dot_q) : DotW'(dot_q);
    if (neg_q) begin
      speed_res = (num_q > NumW'(131072)) ? SPEED_MIN : SpeedW'(~num_q[SpeedW-1:0] + 1'b1);
    end else begin
      speed_res = (num_q > NumW'(131071)) ? SPEED_MAX : num_q[SpeedW-1:0];
    end
    start_hit = !neg_q && ((num_q > NumW'(start_thr_q)) ||
                           ((num_q == NumW'(start_thr_q)) && rem_nz));
    stop_hit  = neg_q || (num_q < NumW'(stop_thr_q));
  end

  // Sequence the phases
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    prod_d      = prod_q;
    sq_d        = sq_q;
    dot_d       = dot_q;
    num_d       = num_q;
    rem_d       = rem_q;
    root_d      = root_q;
    neg_d       = neg_q;
    smp_d       = smp_q;
    zd_d        = zd_q;
    playing_d   = playing_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_smp_d   = out_smp_q;
    out_ev_d    = out_ev_q;
    out_play_d  = out_play_q;
    out_speed_d = out_speed_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ST_MOD;
          cnt_d   = '0;
          num_d   = {clock_count_i, {(NumW-CountW){1'b0}}};
          rem_d   = '0;
          sq_d    = '0;
          dot_d   = '0;
        end
      end
      ST_MOD: begin
        // one remainder bit of clock_count mod divisor
        if (cs_ge) begin
          rem_d = cs_diff[RemW-1:0];
        end else begin
          rem_d = cs_t;
        end
        num_d = {num_q[NumW-2:0], 1'b0};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == MOD_LAST) begin
          cnt_d = '0;
          zd_d  = 1'b0;
          if (rem_d != '0) begin
            smp_d   = 1'b0;
            state_d = ST_DONE;
          end else begin
            smp_d   = 1'b1;
            state_d = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        // issue one product, accumulate the previous one
        prod_d = mul_a * mul_b;
        if (cnt_q != '0) begin
          if (cnt_q <= CntW'(3)) begin
            sq_d = acc_sum[SqW-1:0];
          end else begin
            dot_d = acc_sum;
          end
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == MUL_LAST) begin
          cnt_d   = '0;
          num_d   = {sq_q, {(NumW-SqW){1'b0}}};
          rem_d   = '0;
          root_d  = '0;
          state_d = ST_SQRT;
        end
      end
      ST_SQRT: begin
        // one root bit a step
        if (cs_ge) begin
          rem_d  = cs_diff[RemW-1:0];
          root_d = {root_q[RootW-2:0], 1'b1};
        end else begin
          rem_d  = cs_t;
          root_d = {root_q[RootW-2:0], 1'b0};
        end
        num_d = {num_q[NumW-3:0], 2'b00};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == SQRT_LAST) begin
          cnt_d = '0;
          if (root_d == '0) begin
            zd_d    = 1'b1;
            state_d = ST_DONE;
          end else begin
            num_d   = dot_mag[NumW-1:0];
            neg_d   = dot_q[DotW-1];
            rem_d   = '0;
            state_d = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        // one quotient bit a step; quotient shifts into the dividend register
        if (cs_ge) begin
          rem_d = cs_diff[RemW-1:0];
        end else begin
          rem_d = cs_t;
        end
        num_d = {num_q[NumW-2:0], cs_ge};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == DIV_LAST) begin
          cnt_d   = '0;
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        // load the output register once it is free
        if (out_free) begin
          out_valid_d = 1'b1;
          out_smp_d   = smp_q;
          out_ev_d    = EV_NONE;
          out_speed_d = '0;
          if (smp_q && !zd_q) begin
            out_speed_d = speed_res;
            if (!playing_q && start_hit) begin
              out_ev_d  = EV_RESTART;
              playing_d = 1'b1;
            end else if (playing_q && stop_hit) begin
              out_ev_d  = EV_STOP;
              playing_d = 1'b0;
            end
          end
          out_play_d = playing_d;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      playing_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      playing_q   <= playing_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      vx_q <= vel_x_i;
      vy_q <= vel_y_i;
      vz_q <= vel_z_i;
      dx_q <= OffW'(pos_x_i) - OffW'(anchor_x_i);
      dy_q <= OffW'(pos_y_i) - OffW'(anchor_y_i);
      dz_q <= OffW'(pos_z_i) - OffW'(anchor_z_i);
    end
    prod_d_reg: begin
      prod_q <= prod_d;
    end
    sq_q        <= sq_d;
    dot_q       <= dot_d;
    num_q       <= num_d;
    rem_q       <= rem_d;
    root_q      <= root_d;
    neg_q       <= neg_d;
    smp_q       <= smp_d;
    zd_q        <= zd_d;
    out_smp_q   <= out_smp_d;
    out_ev_q    <= out_ev_d;
    out_play_q  <= out_play_d;
    out_speed_q <= out_speed_d;
  end

  assign out_valid_o    = out_valid_q;
  assign sampled_o      = out_smp_q;
  assign event_res_o    = out_ev_q;
  assign playing_now_o  = out_play_q;
  assign radial_speed_o = out_speed_q;

`ifndef SYNTHESIS
  // A restart leaves the block playing
  a_restart_plays: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (event_res_o == EV_RESTART)) |-> playing_now_o)
    else $error("restart event without playing flag");

  // A stop leaves the block not playing
  a_stop_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (event_res_o == EV_STOP)) |-> !playing_now_o)
    else $error("stop event with playing flag set");

  // An unsampled tick carries no event and no speed
  a_unsampled_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !sampled_o) |-> ((event_res_o == EV_NONE) && (radial_speed_o == '0)))
    else $error("unsampled tick with event or speed");

  // The block is busy in the cycle after it accepts a tick
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("ready right after acceptance");
`endif

endmodule
